// ===== hw/rtl/pit3d_pkg.sv =====
// Shared constants and types for the 3-D point-in-triangle test.
// No dependencies; every other file of the block refers to it by scoped names.
package pit3d_pkg;

  // Coordinate width used when the top level is not overridden.
  localparam int unsigned CoordWidthDefault = 16;

  // Pipeline stages, in the order an item passes through them.
  localparam int unsigned NumStages = 5;
  localparam int unsigned StgDiff   = 0;
  localparam int unsigned StgCross  = 1;
  localparam int unsigned StgProd   = 2;
  localparam int unsigned StgSum    = 3;
  localparam int unsigned StgOut    = 4;

  // Configuration port.
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned TolWidth     = 16;
  localparam int unsigned TolSqWidth   = 2 * TolWidth;
  localparam logic        RegTolSel    = 1'b0;  // word select bit for collinear_tolerance
  localparam logic [TolWidth-1:0]   TolReset   = 16'd7;
  localparam logic [TolSqWidth-1:0] TolSqReset =
      TolSqWidth'(TolReset) * TolSqWidth'(TolReset);

  // Result stream.
  localparam int unsigned OutDataWidth = 8;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NumStages-1:0] en;
  } pit3d_ctrl_t;

endpackage

// ===== hw/rtl/pit3d_pipe_ctrl.sv =====
// Valid and ready bookkeeping for the five-stage pipeline.
// Depends on pit3d_pkg for the stage count and the enable struct.
module pit3d_pipe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pit3d_pkg::pit3d_ctrl_t ctrl_o
);

  localparam int unsigned N = pit3d_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d;
  logic [N:0]   ready;

  // A stage loads when it is empty or its content moves on in this cycle.
  always_comb begin
    ready[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < N; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.en   = ready[N-1:0];
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[N-1];

endmodule

// ===== hw/rtl/pit3d_edge.sv =====
// Same-side test for one triangle edge, spread over four register stages.
// Depends on pit3d_pkg for stage indices, the enable struct and the tolerance width.
module pit3d_edge #(
  parameter int unsigned CoordWidth = pit3d_pkg::CoordWidthDefault
) (
  input  logic                                 clk_i,
  input  pit3d_pkg::pit3d_ctrl_t               ctrl_i,
  input  logic [pit3d_pkg::TolSqWidth-1:0]     tol_sq_i,
  input  logic signed [CoordWidth-1:0]         a_i [3],  // edge start
  input  logic signed [CoordWidth-1:0]         b_i [3],  // edge end
  input  logic signed [CoordWidth-1:0]         p_i [3],  // opposite vertex
  input  logic signed [CoordWidth-1:0]         q_i [3],  // query point
  output logic                                 pass_o
);

  localparam int unsigned W  = CoordWidth;
  localparam int unsigned DW = W + 1;          // coordinate difference
  localparam int unsigned CW = 2 * W + 2;      // cross product component
  localparam int unsigned NW = 2 * W + 2;      // squared length
  localparam int unsigned PW = 4 * W + 4;      // product of two cross components
  localparam int unsigned SW = PW + 1;         // sum of three such products
  localparam int unsigned QW = 4 * W + 2;      // square of a cross component
  localparam int unsigned MW = 2 * NW;         // product of two squared lengths
  localparam int unsigned HW = NW;             // half of that product
  localparam int unsigned TW = pit3d_pkg::TolSqWidth;
  localparam int unsigned LW = TW + HW;        // tolerance times one half
  localparam int unsigned BW = MW + TW;        // full bound

  // Stage: differences.
  logic signed [DW-1:0] u_q [3], v1_q [3], v2_q [3];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[pit3d_pkg::StgDiff]) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i]  <= DW'(b_i[i]) - DW'(a_i[i]);
        v1_q[i] <= DW'(q_i[i]) - DW'(a_i[i]);
        v2_q[i] <= DW'(p_i[i]) - DW'(a_i[i]);
      end
    end
  end

  // Stage: cross products and squared lengths.
  logic signed [CW-1:0] c1_d [3], c2_d [3], c1_q [3], c2_q [3];
  logic [NW-1:0] nu_d, nv_d, nu_q, nv_q;

  function automatic logic signed [CW-1:0] cross_comp(
    input logic signed [DW-1:0] a1, input logic signed [DW-1:0] b2,
    input logic signed [DW-1:0] a2, input logic signed [DW-1:0] b1
  );
    return CW'(a1) * CW'(b2) - CW'(a2) * CW'(b1);
  endfunction

  always_comb begin
    c1_d[0] = cross_comp(u_q[1], v1_q[2], u_q[2], v1_q[1]);
    c1_d[1] = cross_comp(u_q[2], v1_q[0], u_q[0], v1_q[2]);
    c1_d[2] = cross_comp(u_q[0], v1_q[1], u_q[1], v1_q[0]);
    c2_d[0] = cross_comp(u_q[1], v2_q[2], u_q[2], v2_q[1]);
    c2_d[1] = cross_comp(u_q[2], v2_q[0], u_q[0], v2_q[2]);
    c2_d[2] = cross_comp(u_q[0], v2_q[1], u_q[1], v2_q[0]);
    nu_d = '0;
    nv_d = '0;
    for (int i = 0; i < 3; i++) begin
      nu_d = nu_d + NW'(CW'(u_q[i]) * CW'(u_q[i]));
      nv_d = nv_d + NW'(CW'(v1_q[i]) * CW'(v1_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[pit3d_pkg::StgCross]) begin
      c1_q <= c1_d;
      c2_q <= c2_d;
      nu_q <= nu_d;
      nv_q <= nv_d;
    end
  end

  // Stage: the wide products.
  logic signed [PW-1:0] dterm_q [3];
  logic [QW-1:0] c1sq_q [3];
  logic [MW-1:0] m_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[pit3d_pkg::StgProd]) begin
      for (int i = 0; i < 3; i++) begin
        dterm_q[i] <= PW'(c1_q[i]) * PW'(c2_q[i]);
        c1sq_q[i]  <= QW'(PW'(c1_q[i]) * PW'(c1_q[i]));
      end
      m_q <= MW'(nu_q) * MW'(nv_q);
    end
  end

  // Stage: sign of the dot product and the tolerance bound in two halves.
  logic signed [SW-1:0] dot_sum;
  logic          neg_q;
  logic [LW-1:0] plo_q, phi_q;
  logic [QW-1:0] c1sq_s_q [3];

  assign dot_sum = SW'(dterm_q[0]) + SW'(dterm_q[1]) + SW'(dterm_q[2]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[pit3d_pkg::StgSum]) begin
      neg_q    <= dot_sum[SW-1];
      plo_q    <= LW'(tol_sq_i) * LW'(m_q[HW-1:0]);
      phi_q    <= LW'(tol_sq_i) * LW'(m_q[MW-1:HW]);
      c1sq_s_q <= c1sq_q;
    end
  end

  // A negative dot product is forgiven when every cross component of the
  // query lies within the scaled tolerance.
  logic [BW-1:0] bound;
  logic [2:0]    near;

  assign bound = (BW'(phi_q) << HW) + BW'(plo_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      near[i] = BW'({c1sq_s_q[i], {TW{1'b0}}}) <= bound;
    end
  end

  assign pass_o = !neg_q || (&near);

endmodule

// ===== hw/rtl/point_in_triangle_3d_test.sv =====
// Channel   | Dir | Handshake                      | Contents
// ----------+-----+--------------------------------+----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | A, B, C and query point, 12 coordinates
// m_axis    | out | m_axis_tvalid / m_axis_tready  | is_inside in bit 0
// APB       | in  | psel & penable & pwrite        | collinear_tolerance at address 0
//
// One request is taken per cycle while m_axis is not stalled; each result passes through
// the four register stages of the edge datapath and then the output register.
// Reset clears all valid bits and loads the tolerance with 7.
// A stall on m_axis holds only occupied stages with no empty stage after them, so
// no request is lost or repeated. Depends on pit3d_pkg, pit3d_pipe_ctrl, pit3d_edge.
module point_in_triangle_3d_test #(
  parameter int unsigned CoordWidth = pit3d_pkg::CoordWidthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
  // vertex_c_x, vertex_c_y, vertex_c_z, query_x, query_y, query_z (lowest first)
  input  logic [((12*CoordWidth+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // is_inside in bit 0, zeros above
  output logic [pit3d_pkg::OutDataWidth-1:0]   m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pit3d_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [pit3d_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [pit3d_pkg::CfgDataWidth-1:0]   prdata,
  output logic                                 pready
);

  localparam int unsigned W  = CoordWidth;
  localparam int unsigned TW = pit3d_pkg::TolWidth;
  localparam int unsigned SW = pit3d_pkg::TolSqWidth;

  // Configuration register and its square, kept together.
  logic [TW-1:0] tol_q;
  logic [SW-1:0] tol_sq_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == pit3d_pkg::RegTolSel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= pit3d_pkg::TolReset;
      tol_sq_q <= pit3d_pkg::TolSqReset;
    end else if (cfg_wr) begin
      tol_q    <= pwdata[TW-1:0];
      tol_sq_q <= SW'(pwdata[TW-1:0]) * SW'(pwdata[TW-1:0]);
    end
  end

  assign prdata = (paddr[2] == pit3d_pkg::RegTolSel) ?
                  pit3d_pkg::CfgDataWidth'(tol_q) : '0;

  // Pipeline control.
  pit3d_pkg::pit3d_ctrl_t ctrl;

  pit3d_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  // Unpack the request.
  logic signed [W-1:0] va [3], vb [3], vc [3], vq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = s_axis_tdata[(0 + i)*W +: W];
      vb[i] = s_axis_tdata[(3 + i)*W +: W];
      vc[i] = s_axis_tdata[(6 + i)*W +: W];
      vq[i] = s_axis_tdata[(9 + i)*W +: W];
    end
  end

  logic [2:0] pass;

  // Edge B-C against vertex A.
  pit3d_edge #(.CoordWidth(W)) u_edge_bc (
    .clk_i (clk_i), .ctrl_i (ctrl), .tol_sq_i (tol_sq_q),
    .a_i (vb), .b_i (vc), .p_i (va), .q_i (vq), .pass_o (pass[0])
  );

  // Edge A-C against vertex B.
  pit3d_edge #(.CoordWidth(W)) u_edge_ac (
    .clk_i (clk_i), .ctrl_i (ctrl), .tol_sq_i (tol_sq_q),
    .a_i (va), .b_i (vc), .p_i (vb), .q_i (vq), .pass_o (pass[1])
  );

  // Edge A-B against vertex C.
  pit3d_edge #(.CoordWidth(W)) u_edge_ab (
    .clk_i (clk_i), .ctrl_i (ctrl), .tol_sq_i (tol_sq_q),
    .a_i (va), .b_i (vb), .p_i (vc), .q_i (vq), .pass_o (pass[2])
  );

  // Output register.
  logic inside_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.en[pit3d_pkg::StgOut]) begin
      inside_q <= &pass;
    end
  end

  assign m_axis_tdata = pit3d_pkg::OutDataWidth'(inside_q);

endmodule

// ===== hw/rtl/pit3d_checker.sv =====
// Port-level checks for point_in_triangle_3d_test, attached with a bind.
// Depends on pit3d_pkg for port widths.
module pit3d_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic [pit3d_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [pit3d_pkg::CfgAddrWidth-1:0]  paddr,
  input logic [pit3d_pkg::CfgDataWidth-1:0]  pwdata,
  input logic [pit3d_pkg::CfgDataWidth-1:0]  prdata,
  input logic                                pready
);

  localparam int unsigned TW = pit3d_pkg::TolWidth;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Only bit 0 of a result carries information.
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[pit3d_pkg::OutDataWidth-1:1] == '0)
    else $error("result padding not zero");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // A tolerance write reads back in the following cycle.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[2] == pit3d_pkg::RegTolSel)
    ##1 (psel && !pwrite && paddr[2] == pit3d_pkg::RegTolSel)
    |-> prdata == pit3d_pkg::CfgDataWidth'($past(pwdata[TW-1:0])))
    else $error("tolerance readback mismatch");

endmodule

bind point_in_triangle_3d_test pit3d_checker u_pit3d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
